[rtl/thc_pkg.sv]
// ----------------------------------------------------------------------------
// Texton histogram classifier package
// Shared widths, defaults, item codes and the controller/datapath interface.
// ----------------------------------------------------------------------------
package thc_pkg;

   // Defaults for the top-level parameters
   localparam int MAX_TEXTONS_DEF  = 32;
   localparam int PATCH_PIXELS_DEF = 25;
   localparam int COUNT_WIDTH_DEF  = 16;

   // Fixed field widths
   localparam int KIND_W = 2;
   localparam int TSEL_W = 5;
   localparam int ESEL_W = 5;
   localparam int CODE_W = 16;
   localparam int PIX_W  = 8;
   localparam int IDX_W  = 5;
   localparam int SUM_W  = 21;
   localparam int CFG_W  = 6;

   localparam logic [CFG_W-1:0] TEXTON_COUNT_RESET = 6'd30;
   localparam logic [SUM_W-1:0] SUM_MAX            = '1;

   typedef enum logic [KIND_W-1:0] {
      KIND_LOAD    = 2'd0,
      KIND_PIXEL   = 2'd1,
      KIND_READOUT = 2'd2
   } kind_type;

   localparam logic RESULT_CLASS = 1'b0;
   localparam logic RESULT_BIN   = 1'b1;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic cb_write;    // write codebook word from the input item
      logic px_start;    // latch pixel, rewind the sweep
      logic sweep_step;  // issue reads for one texton
      logic sweep_done;  // last write-back of the sweep, advance position
      logic hist_read;   // read the winning bin
      logic bump;        // bump winning bin, load classification result
      logic rd_start;    // rewind the readout index
      logic rd_issue;    // read the bin at the readout index
      logic rd_emit;     // load one readout result, advance
   } cmd_type;

   // Status from the datapath to the controller
   typedef struct packed {
      logic sweep_end;   // sweep index at the last texton
      logic last_px;     // current pixel closes the patch
      logic rd_last;     // readout index at the last bin in use
      logic out_free;    // result register can take a new result
   } status_type;

endpackage

[rtl/thc_datapath.sv]
// ----------------------------------------------------------------------------
// Texton histogram classifier datapath
// Codebook, distance sums, histogram, shared subtract-abs-add unit and the
// result register.
// ----------------------------------------------------------------------------
module thc_datapath #(
   parameter int MAX_TEXTONS  = thc_pkg::MAX_TEXTONS_DEF,
   parameter int PATCH_PIXELS = thc_pkg::PATCH_PIXELS_DEF,
   parameter int COUNT_WIDTH  = thc_pkg::COUNT_WIDTH_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  thc_pkg::cmd_type              cmd,
   output thc_pkg::status_type           sts,
   input  logic                          csr_write_enable,
   input  logic [thc_pkg::CFG_W-1:0]     csr_write_data,
   input  logic [thc_pkg::TSEL_W-1:0]    req_texton_select,
   input  logic [thc_pkg::ESEL_W-1:0]    req_element_select,
   input  logic [thc_pkg::CODE_W-1:0]    req_codeword_value,
   input  logic [thc_pkg::PIX_W-1:0]     req_pixel_value,
   input  logic                          rsp_stall,
   output logic                          rsp_valid,
   output logic                          rsp_result_kind,
   output logic [thc_pkg::IDX_W-1:0]     rsp_texton_index,
   output logic [thc_pkg::SUM_W-1:0]     rsp_match_distance,
   output logic [COUNT_WIDTH-1:0]        rsp_bin_count,
   output logic                          rsp_last
);
   import thc_pkg::*;

   localparam int TW       = $clog2(MAX_TEXTONS);
   localparam int PW       = $clog2(PATCH_PIXELS);
   localparam int CB_DEPTH = MAX_TEXTONS * PATCH_PIXELS;
   localparam int CBW      = $clog2(CB_DEPTH);

   // Memories
   logic [CODE_W-1:0]      cb_mem_ff   [CB_DEPTH];
   logic [SUM_W-1:0]       sum_mem_ff  [MAX_TEXTONS];
   logic [COUNT_WIDTH-1:0] hist_mem_ff [MAX_TEXTONS];

   // Control registers
   logic [CFG_W-1:0]       texton_count_ff, texton_count_in;
   logic [TW-1:0]          t_ff, t_in;
   logic [CBW-1:0]         cb_addr_ff, cb_addr_in;
   logic [PW-1:0]          pos_ff, pos_in;
   logic                   s1_vld_ff, s1_vld_in;
   logic [MAX_TEXTONS-1:0] sum_vld_ff, sum_vld_in;
   logic [MAX_TEXTONS-1:0] hist_vld_ff, hist_vld_in;
   logic                   rsp_valid_ff, rsp_valid_in;

   // Payload registers
   logic [PIX_W-1:0]       pix_ff, pix_in;
   logic [TW-1:0]          s1_t_ff;
   logic [CODE_W-1:0]      cb_rd_ff;
   logic [SUM_W-1:0]       sum_rd_ff;
   logic                   sum_rd_vld_ff;
   logic [COUNT_WIDTH-1:0] hist_rd_ff;
   logic                   hist_rd_vld_ff;
   logic [TW-1:0]          best_ff, best_in;
   logic [SUM_W-1:0]       best_sum_ff, best_sum_in;
   logic                   rsp_result_kind_ff, rsp_result_kind_in;
   logic [IDX_W-1:0]       rsp_texton_index_ff, rsp_texton_index_in;
   logic [SUM_W-1:0]       rsp_match_distance_ff, rsp_match_distance_in;
   logic [COUNT_WIDTH-1:0] rsp_bin_count_ff, rsp_bin_count_in;
   logic                   rsp_last_ff, rsp_last_in;

   // Combinational
   logic [TW-1:0]          last_t;
   logic                   cb_wr_ok;
   logic [CBW-1:0]         cb_wr_addr;
   logic [CODE_W-1:0]      px_q;
   logic [CODE_W-1:0]      diff;
   logic [SUM_W-1:0]       sum_old;
   logic [SUM_W:0]         sum_wide;
   logic [SUM_W-1:0]       sum_new;
   logic                   take_best;
   logic [TW-1:0]          hist_addr;
   logic                   hist_rd_en;
   logic [COUNT_WIDTH-1:0] cnt_cur;
   logic [COUNT_WIDTH-1:0] cnt_bumped;
   logic                   rsp_load;

   // Last texton in use: clamp the register to 1..MAX_TEXTONS
   always_comb begin
      if (texton_count_ff == '0) begin
         last_t = '0;
      end else if (32'(texton_count_ff) > 32'(MAX_TEXTONS)) begin
         last_t = TW'(MAX_TEXTONS - 1);
      end else begin
         last_t = TW'(32'(texton_count_ff) - 32'd1);
      end
   end

   assign texton_count_in = csr_write_enable ? csr_write_data : texton_count_ff;

   // Codebook write port
   assign cb_wr_ok = cmd.cb_write
                     && (32'(req_texton_select) < 32'(MAX_TEXTONS))
                     && (32'(req_element_select) < 32'(PATCH_PIXELS));
   assign cb_wr_addr = CBW'(32'(req_texton_select) * 32'(PATCH_PIXELS)
                            + 32'(req_element_select));

   always_ff @(posedge clock) begin
      if (cb_wr_ok) begin
         cb_mem_ff[cb_wr_addr] <= req_codeword_value;
      end
      cb_rd_ff <= cb_mem_ff[cb_addr_ff];
   end

   // Sweep sequencing
   always_comb begin
      t_in       = t_ff;
      cb_addr_in = cb_addr_ff;
      pix_in     = pix_ff;
      pos_in     = pos_ff;
      if (cmd.px_start || cmd.rd_start) begin
         t_in = '0;
      end else if (cmd.sweep_step || cmd.rd_emit) begin
         t_in = t_ff + TW'(1);
      end
      if (cmd.px_start) begin
         cb_addr_in = CBW'(pos_ff);
         pix_in     = req_pixel_value;
      end else if (cmd.sweep_step) begin
         cb_addr_in = cb_addr_ff + CBW'(PATCH_PIXELS);
      end
      if (cmd.sweep_done) begin
         pos_in = sts.last_px ? '0 : pos_ff + PW'(1);
      end
   end

   assign s1_vld_in = cmd.sweep_step;

   // Distance sum read port
   always_ff @(posedge clock) begin
      s1_t_ff       <= t_ff;
      sum_rd_ff     <= sum_mem_ff[t_ff];
      sum_rd_vld_ff <= sum_vld_ff[t_ff];
      if (s1_vld_ff) begin
         sum_mem_ff[s1_t_ff] <= sum_new;
      end
   end

   // Shared subtract-abs-add unit, saturating
   assign px_q     = {pix_ff, 8'h00};
   assign diff     = (cb_rd_ff > px_q) ? (cb_rd_ff - px_q) : (px_q - cb_rd_ff);
   assign sum_old  = sum_rd_vld_ff ? sum_rd_ff : '0;
   assign sum_wide = {1'b0, sum_old} + (SUM_W + 1)'(diff);
   assign sum_new  = sum_wide[SUM_W] ? SUM_MAX : sum_wide[SUM_W-1:0];

   // Running minimum on the closing pixel; strict compare keeps the lowest index
   assign take_best = s1_vld_ff && sts.last_px
                      && ((s1_t_ff == '0)
                          || ((s1_t_ff <= last_t) && (sum_new < best_sum_ff)));

   always_comb begin
      best_in     = best_ff;
      best_sum_in = best_sum_ff;
      if (take_best) begin
         best_in     = s1_t_ff;
         best_sum_in = sum_new;
      end
   end

   always_comb begin
      sum_vld_in = sum_vld_ff;
      if (s1_vld_ff) begin
         sum_vld_in[s1_t_ff] = 1'b1;
      end
      if (cmd.sweep_done && sts.last_px) begin
         sum_vld_in = '0;
      end
   end

   // Histogram
   assign hist_addr  = cmd.hist_read ? best_ff : t_ff;
   assign hist_rd_en = cmd.hist_read || cmd.rd_issue;

   always_ff @(posedge clock) begin
      if (hist_rd_en) begin
         hist_rd_ff     <= hist_mem_ff[hist_addr];
         hist_rd_vld_ff <= hist_vld_ff[hist_addr];
      end
      if (cmd.bump) begin
         hist_mem_ff[best_ff] <= cnt_bumped;
      end
   end

   assign cnt_cur    = hist_rd_vld_ff ? hist_rd_ff : '0;
   assign cnt_bumped = (&cnt_cur) ? cnt_cur : cnt_cur + COUNT_WIDTH'(1);

   always_comb begin
      hist_vld_in = hist_vld_ff;
      if (cmd.bump) begin
         hist_vld_in[best_ff] = 1'b1;
      end
      if (cmd.rd_emit && sts.rd_last) begin
         hist_vld_in = '0;
      end
   end

   // Result register
   assign rsp_load = cmd.bump || cmd.rd_emit;

   always_comb begin
      rsp_valid_in          = rsp_valid_ff;
      rsp_result_kind_in    = rsp_result_kind_ff;
      rsp_texton_index_in   = rsp_texton_index_ff;
      rsp_match_distance_in = rsp_match_distance_ff;
      rsp_bin_count_in      = rsp_bin_count_ff;
      rsp_last_in           = rsp_last_ff;
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.bump) begin
         rsp_valid_in          = 1'b1;
         rsp_result_kind_in    = RESULT_CLASS;
         rsp_texton_index_in   = IDX_W'(best_ff);
         rsp_match_distance_in = best_sum_ff;
         rsp_bin_count_in      = cnt_bumped;
         rsp_last_in           = 1'b1;
      end else if (cmd.rd_emit) begin
         rsp_valid_in          = 1'b1;
         rsp_result_kind_in    = RESULT_BIN;
         rsp_texton_index_in   = IDX_W'(t_ff);
         rsp_match_distance_in = '0;
         rsp_bin_count_in      = cnt_cur;
         rsp_last_in           = sts.rd_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         texton_count_ff <= TEXTON_COUNT_RESET;
         t_ff            <= '0;
         cb_addr_ff      <= '0;
         pos_ff          <= '0;
         s1_vld_ff       <= 1'b0;
         sum_vld_ff      <= '0;
         hist_vld_ff     <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         texton_count_ff <= texton_count_in;
         t_ff            <= t_in;
         cb_addr_ff      <= cb_addr_in;
         pos_ff          <= pos_in;
         s1_vld_ff       <= s1_vld_in;
         sum_vld_ff      <= sum_vld_in;
         hist_vld_ff     <= hist_vld_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pix_ff                <= pix_in;
      best_ff               <= best_in;
      best_sum_ff           <= best_sum_in;
      rsp_result_kind_ff    <= rsp_result_kind_in;
      rsp_texton_index_ff   <= rsp_texton_index_in;
      rsp_match_distance_ff <= rsp_match_distance_in;
      rsp_bin_count_ff      <= rsp_bin_count_in;
      rsp_last_ff           <= rsp_last_in;
   end

   // Status
   assign sts.sweep_end = (t_ff == TW'(MAX_TEXTONS - 1));
   assign sts.last_px   = (pos_ff == PW'(PATCH_PIXELS - 1));
   assign sts.rd_last   = (t_ff == last_t);
   assign sts.out_free  = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_result_kind    = rsp_result_kind_ff;
   assign rsp_texton_index   = rsp_texton_index_ff;
   assign rsp_match_distance = rsp_match_distance_ff;
   assign rsp_bin_count      = rsp_bin_count_ff;
   assign rsp_last           = rsp_last_ff;

`ifndef SYNTHESIS
   a_load_into_free_reg: assert property (@(posedge clock) disable iff (reset)
      rsp_load |-> (!rsp_valid_ff || !rsp_stall))
      else $error("result loaded over a pending result");

   a_bump_shows_class: assert property (@(posedge clock) disable iff (reset)
      cmd.bump |=> (rsp_valid_ff && rsp_last_ff && (rsp_result_kind_ff == RESULT_CLASS)))
      else $error("classification result not presented after bump");

   a_pos_in_patch: assert property (@(posedge clock) disable iff (reset)
      pos_ff <= PW'(PATCH_PIXELS - 1))
      else $error("pixel position beyond patch");

   a_readout_clears: assert property (@(posedge clock) disable iff (reset)
      (cmd.rd_emit && sts.rd_last) |=> (hist_vld_ff == '0))
      else $error("histogram not cleared after readout");
`endif

endmodule

[rtl/thc_controller.sv]
// ----------------------------------------------------------------------------
// Texton histogram classifier controller
// Sequences codebook loads, per-pixel sweeps, bin bumps and readouts.
// ----------------------------------------------------------------------------
module thc_controller (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   input  logic [thc_pkg::KIND_W-1:0] req_kind,
   output logic                       req_stall,
   output thc_pkg::cmd_type           cmd,
   input  thc_pkg::status_type        sts
);
   import thc_pkg::*;

   typedef enum logic [6:0] {
      ST_IDLE  = 7'b000_0001,
      ST_SWEEP = 7'b000_0010,
      ST_DRAIN = 7'b000_0100,
      ST_HREAD = 7'b000_1000,
      ST_HBUMP = 7'b001_0000,
      ST_RDISS = 7'b010_0000,
      ST_RDOUT = 7'b100_0000
   } state_type;

   state_type state_ff, state_in;
   logic      req_xfer;

   assign req_stall = (state_ff != ST_IDLE);
   assign req_xfer  = req_valid && !req_stall;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               case (req_kind)
                  KIND_LOAD: begin
                     cmd.cb_write = 1'b1;
                  end
                  KIND_PIXEL: begin
                     cmd.px_start = 1'b1;
                     state_in     = ST_SWEEP;
                  end
                  KIND_READOUT: begin
                     cmd.rd_start = 1'b1;
                     state_in     = ST_RDISS;
                  end
                  default: begin
                     // drop unused kind
                  end
               endcase
            end
         end
         ST_SWEEP: begin
            cmd.sweep_step = 1'b1;
            if (sts.sweep_end) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            cmd.sweep_done = 1'b1;
            state_in       = sts.last_px ? ST_HREAD : ST_IDLE;
         end
         ST_HREAD: begin
            cmd.hist_read = 1'b1;
            state_in      = ST_HBUMP;
         end
         ST_HBUMP: begin
            if (sts.out_free) begin
               cmd.bump = 1'b1;
               state_in = ST_IDLE;
            end
         end
         ST_RDISS: begin
            cmd.rd_issue = 1'b1;
            state_in     = ST_RDOUT;
         end
         ST_RDOUT: begin
            if (sts.out_free) begin
               cmd.rd_emit = 1'b1;
               state_in    = sts.rd_last ? ST_IDLE : ST_RDISS;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

`ifndef SYNTHESIS
   a_close_goes_bump: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_DRAIN) && sts.last_px) |=> (state_ff == ST_HREAD))
      else $error("closing pixel did not lead to a bin bump");

   a_sweep_runs_out: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_SWEEP) && !sts.sweep_end) |=> (state_ff == ST_SWEEP))
      else $error("sweep left before the last texton");

   a_bump_waits: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_HBUMP) && !sts.out_free) |=> (state_ff == ST_HBUMP))
      else $error("bump left while result register busy");
`endif

endmodule

[rtl/texton_histogram_classifier_core.sv]
// ----------------------------------------------------------------------------
// Texton histogram classifier core
// Nearest-codeword L1 classifier of grey patches with a saturating histogram.
// ----------------------------------------------------------------------------
//
//  Channel  Ports                        Direction  Transfer when
//  req      req_valid / req_stall        in         req_valid && !req_stall
//  rsp      rsp_valid / rsp_stall        out        rsp_valid && !rsp_stall
//  csr      csr_write_enable / _data     in         csr_write_enable
//
//  Codebook load: written as it is taken. Pixel: the single subtract-abs-add
//  unit walks one texton per cycle over the codebook memory port, then drains;
//  a patch's closing pixel adds a histogram read and the bin bump. Readout:
//  a registered histogram read, then a result, for each bin in use.
//  Reset is synchronous; sums and bins carry valid bits, so no clearing pass.
//  A stalled result holds in the output register; the block keeps taking
//  transfers until it needs that register again.
//
module texton_histogram_classifier_core #(
   parameter int MAX_TEXTONS  = thc_pkg::MAX_TEXTONS_DEF,
   parameter int PATCH_PIXELS = thc_pkg::PATCH_PIXELS_DEF,
   parameter int COUNT_WIDTH  = thc_pkg::COUNT_WIDTH_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   // configuration
   input  logic                       csr_write_enable,
   input  logic [thc_pkg::CFG_W-1:0]  csr_write_data,
   // request channel
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic [thc_pkg::KIND_W-1:0] req_kind,
   input  logic [thc_pkg::TSEL_W-1:0] req_texton_select,
   input  logic [thc_pkg::ESEL_W-1:0] req_element_select,
   input  logic [thc_pkg::CODE_W-1:0] req_codeword_value,
   input  logic [thc_pkg::PIX_W-1:0]  req_pixel_value,
   // response channel
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic                       rsp_result_kind,
   output logic [thc_pkg::IDX_W-1:0]  rsp_texton_index,
   output logic [thc_pkg::SUM_W-1:0]  rsp_match_distance,
   output logic [COUNT_WIDTH-1:0]     rsp_bin_count,
   output logic                       rsp_last
);
   import thc_pkg::*;

   // Controller drives commands, datapath reports status; nothing else crosses.
   cmd_type    cmd;
   status_type sts;

   thc_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_kind  (req_kind),
      .req_stall (req_stall),
      .cmd       (cmd),
      .sts       (sts)
   );

   // Datapath holds the codebook, the per-texton distance sums, the
   // histogram and the result register.
   thc_datapath #(
      .MAX_TEXTONS  (MAX_TEXTONS),
      .PATCH_PIXELS (PATCH_PIXELS),
      .COUNT_WIDTH  (COUNT_WIDTH)
   ) u_dp (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .sts                (sts),
      .csr_write_enable   (csr_write_enable),
      .csr_write_data     (csr_write_data),
      .req_texton_select  (req_texton_select),
      .req_element_select (req_element_select),
      .req_codeword_value (req_codeword_value),
      .req_pixel_value    (req_pixel_value),
      .rsp_stall          (rsp_stall),
      .rsp_valid          (rsp_valid),
      .rsp_result_kind    (rsp_result_kind),
      .rsp_texton_index   (rsp_texton_index),
      .rsp_match_distance (rsp_match_distance),
      .rsp_bin_count      (rsp_bin_count),
      .rsp_last           (rsp_last)
   );

endmodule

[tb/texton_histogram_classifier_core_tb.sv]
// ----------------------------------------------------------------------------
// Texton histogram classifier core testbench
// Loads the full codebook and then runs directed patches: flat extremes, the
// largest distance with one texton in use, a tie between textons and a
// readout in the middle of a patch. A long random part follows, with the
// texton count changed between phases and random idling on both channels.
// A scoreboard predicts every classification and bin readout and compares
// each result, field by field. The bins do not reach saturation in a run of
// this length, and the distance sums cannot reach it for any field values.
// ----------------------------------------------------------------------------
module texton_histogram_classifier_core_tb;
   import thc_pkg::*;

   localparam int NUM_TEXTONS   = MAX_TEXTONS_DEF;
   localparam int PATCH_LEN     = PATCH_PIXELS_DEF;
   localparam int BIN_W         = COUNT_WIDTH_DEF;
   localparam int unsigned SUM_LIMIT = SUM_MAX;
   localparam int unsigned BIN_LIMIT = (1 << BIN_W) - 1;
   // Kind 3 carries no operation; the block drops it
   localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
   // Longest pixel sweep plus the bin bump, with margin
   localparam int SETTLE_CYCLES = 48;
   localparam int RANDOM_ITEMS  = 400;
   localparam int RANDOM_PATCHES = 12;
   localparam int RUN_LIMIT     = 24_000_000;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [TSEL_W-1:0] texton_sel;
      logic [ESEL_W-1:0] element_sel;
      logic [CODE_W-1:0] codeword;
      logic [PIX_W-1:0]  pixel;
   } req_item_type;

   typedef struct packed {
      logic             result_kind;
      logic [IDX_W-1:0] texton_index;
      logic [SUM_W-1:0] match_distance;
      logic [BIN_W-1:0] bin_count;
      logic             last;
   } texton_report_type;

   // ------------------------------------------------------------------------
   // Clock, reset and block inputs, all known from time zero
   // ------------------------------------------------------------------------
   logic clock = 1'b0;
   logic reset = 1'b1;

   logic              csr_write_enable   = 1'b0;
   logic [CFG_W-1:0]  csr_write_data     = '0;
   logic              req_valid          = 1'b0;
   logic              req_stall;
   logic [KIND_W-1:0] req_kind           = '0;
   logic [TSEL_W-1:0] req_texton_select  = '0;
   logic [ESEL_W-1:0] req_element_select = '0;
   logic [CODE_W-1:0] req_codeword_value = '0;
   logic [PIX_W-1:0]  req_pixel_value    = '0;
   logic              rsp_valid;
   logic              rsp_stall          = 1'b0;
   logic              rsp_result_kind;
   logic [IDX_W-1:0]  rsp_texton_index;
   logic [SUM_W-1:0]  rsp_match_distance;
   logic [BIN_W-1:0]  rsp_bin_count;
   logic              rsp_last;

   always #6 clock = ~clock;

   texton_histogram_classifier_core dut (
      .clock              (clock),
      .reset              (reset),
      .csr_write_enable   (csr_write_enable),
      .csr_write_data     (csr_write_data),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_kind           (req_kind),
      .req_texton_select  (req_texton_select),
      .req_element_select (req_element_select),
      .req_codeword_value (req_codeword_value),
      .req_pixel_value    (req_pixel_value),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_result_kind    (rsp_result_kind),
      .rsp_texton_index   (rsp_texton_index),
      .rsp_match_distance (rsp_match_distance),
      .rsp_bin_count      (rsp_bin_count),
      .rsp_last           (rsp_last)
   );

   // ------------------------------------------------------------------------
   // Shadow state of the classifier: codebook, running L1 sums, patch
   // position, bins and the texton count register
   // ------------------------------------------------------------------------
   bit [CODE_W-1:0]  codebook_model [NUM_TEXTONS][PATCH_LEN];
   int unsigned      distance_model [NUM_TEXTONS];
   int unsigned      histogram_model [NUM_TEXTONS];
   int unsigned      patch_position;
   logic [CFG_W-1:0] texton_count_setting = TEXTON_COUNT_RESET;

   texton_report_type reports_due [$];
   texton_report_type oldest_report;

   int unsigned useful_items;
   int unsigned patches_classified;
   int unsigned mismatch_count;
   int unsigned rsp_hold;
   bit          req_quiet;
   bit          rsp_quiet;

   // A count of zero still searches one texton; counts past the codebook
   // size are clamped to it
   function automatic int unsigned textons_searched();
      if (texton_count_setting == 0) return 1;
      if (texton_count_setting > NUM_TEXTONS) return NUM_TEXTONS;
      return texton_count_setting;
   endfunction

   // Advance the shadow state by one accepted transfer and queue the results
   // it causes
   task automatic score_texton_item(input req_item_type item);
      int unsigned searched;
      int unsigned best;
      int unsigned grey;
      int unsigned word;
      int unsigned gap;
      int unsigned total;
      texton_report_type report;
      searched = textons_searched();
      if (item.kind == KIND_LOAD) begin
         // Writes past the end of a patch are dropped
         if (item.element_sel < PATCH_LEN)
            codebook_model[item.texton_sel][item.element_sel] = item.codeword;
      end else if (item.kind == KIND_PIXEL) begin
         grey = {item.pixel, 8'h00};
         // Every texton accumulates, in use or not
         for (int t = 0; t < NUM_TEXTONS; t++) begin
            word = codebook_model[t][patch_position];
            gap = (word > grey) ? word - grey : grey - word;
            total = distance_model[t] + gap;
            distance_model[t] = (total > SUM_LIMIT) ? SUM_LIMIT : total;
         end
         patch_position++;
         if (patch_position == PATCH_LEN) begin
            // Strict less-than keeps the lowest index on a tie
            best = 0;
            for (int t = 1; t < searched; t++)
               if (distance_model[t] < distance_model[best]) best = t;
            if (histogram_model[best] < BIN_LIMIT) histogram_model[best]++;
            report.result_kind    = RESULT_CLASS;
            report.texton_index   = best[IDX_W-1:0];
            report.match_distance = distance_model[best][SUM_W-1:0];
            report.bin_count      = histogram_model[best][BIN_W-1:0];
            report.last           = 1'b1;
            reports_due.push_back(report);
            patches_classified++;
            for (int t = 0; t < NUM_TEXTONS; t++) distance_model[t] = 0;
            patch_position = 0;
         end
      end else if (item.kind == KIND_READOUT) begin
         for (int t = 0; t < searched; t++) begin
            report.result_kind    = RESULT_BIN;
            report.texton_index   = t[IDX_W-1:0];
            report.match_distance = '0;
            report.bin_count      = histogram_model[t][BIN_W-1:0];
            report.last           = (t == searched - 1);
            reports_due.push_back(report);
         end
         for (int t = 0; t < NUM_TEXTONS; t++) histogram_model[t] = 0;
      end
   endtask

   // ------------------------------------------------------------------------
   // Result side: draw a stall length for each result, then check it
   // against the oldest prediction when the transfer happens
   // ------------------------------------------------------------------------
   task automatic check_field(input string field, input int unsigned want,
                              input int unsigned got);
      if (want != got) begin
         $display("%0t: %s expected %0d, actual %0d", $time, field, want, got);
         mismatch_count++;
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (reports_due.size() == 0) begin
            $display("%0t: result kind %0d index %0d expected none, actual one arrived",
                     $time, rsp_result_kind, rsp_texton_index);
            mismatch_count++;
         end else begin
            oldest_report = reports_due.pop_front();
            check_field("result_kind", oldest_report.result_kind, rsp_result_kind);
            check_field("texton_index", oldest_report.texton_index, rsp_texton_index);
            check_field("match_distance", oldest_report.match_distance,
                        rsp_match_distance);
            check_field("bin_count", oldest_report.bin_count, rsp_bin_count);
            check_field("last", oldest_report.last, rsp_last);
         end
         // Wait this many cycles on the next result before taking it
         rsp_hold = rsp_quiet ? 0 : $urandom_range(0, 19);
      end else if (rsp_valid && rsp_hold != 0) begin
         rsp_hold--;
      end
      rsp_stall <= (rsp_hold != 0);
   end

   // ------------------------------------------------------------------------
   // Request side
   // ------------------------------------------------------------------------

   // Present one item after a random gap, hold it until the transfer, then
   // score it. Valid stays high into the next call so back-to-back items
   // never see valid lowered and raised in the same step.
   task automatic send_request(input req_item_type item);
      int unsigned gap;
      gap = req_quiet ? 0 : $urandom_range(0, 19);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid          <= 1'b1;
      req_kind           <= item.kind;
      req_texton_select  <= item.texton_sel;
      req_element_select <= item.element_sel;
      req_codeword_value <= item.codeword;
      req_pixel_value    <= item.pixel;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      score_texton_item(item);
      if (item.kind != KIND_UNUSED &&
          !(item.kind == KIND_LOAD && item.element_sel >= PATCH_LEN))
         useful_items++;
   endtask

   // Fill the fields that the kind does not use with noise
   function automatic req_item_type random_item(input logic [KIND_W-1:0] kind);
      req_item_type item;
      item.kind        = kind;
      item.texton_sel  = TSEL_W'($urandom_range(0, 31));
      item.element_sel = ESEL_W'($urandom_range(0, 31));
      item.codeword    = CODE_W'($urandom_range(0, 65535));
      item.pixel       = PIX_W'($urandom_range(0, 255));
      return item;
   endfunction

   task automatic send_load(input int unsigned texton, input int unsigned element,
                            input int unsigned word);
      req_item_type item;
      item = random_item(KIND_LOAD);
      item.texton_sel  = TSEL_W'(texton);
      item.element_sel = ESEL_W'(element);
      item.codeword    = CODE_W'(word);
      send_request(item);
   endtask

   task automatic send_pixel(input logic [PIX_W-1:0] level);
      req_item_type item;
      item = random_item(KIND_PIXEL);
      item.pixel = level;
      send_request(item);
   endtask

   task automatic send_readout();
      send_request(random_item(KIND_READOUT));
   endtask

   // Kind 3, or a codebook write past the end of a patch: no effect at all
   task automatic send_noise();
      req_item_type item;
      item = random_item(KIND_UNUSED);
      if ($urandom_range(0, 1) == 1) begin
         item.kind        = KIND_LOAD;
         item.element_sel = ESEL_W'($urandom_range(PATCH_LEN, 31));
      end
      send_request(item);
   endtask

   // Grey level close to one codebook element, so the patch lands on it
   function automatic logic [PIX_W-1:0] grey_near(input int unsigned texton,
                                                  input int unsigned element);
      int level;
      level = int'(codebook_model[texton][element][15:8]);
      level = level + int'($urandom_range(0, 6)) - 3;
      if (level < 0) level = 0;
      if (level > 255) level = 255;
      return level[PIX_W-1:0];
   endfunction

   task automatic send_flat_patch(input logic [PIX_W-1:0] level);
      repeat (PATCH_LEN) send_pixel(level);
   endtask

   // One whole patch, near a texton or scattered, with an occasional readout
   // or codebook write slipped in between pixels
   task automatic send_patch(input int unsigned texton, input bit scattered);
      int unsigned pick;
      repeat (PATCH_LEN) begin
         pick = $urandom_range(0, 49);
         if (pick == 0)
            send_readout();
         else if (pick == 1)
            send_load($urandom_range(0, 31), $urandom_range(0, PATCH_LEN - 1),
                      $urandom_range(0, 65535));
         send_pixel(scattered ? PIX_W'($urandom_range(0, 255))
                              : grey_near(texton, patch_position));
      end
   endtask

   // Drop valid, wait for every predicted result, then let a pixel sweep
   // that produces no result run out
   task automatic drain_block();
      req_valid <= 1'b0;
      while (reports_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Change the texton count only once the block has gone quiet
   task automatic write_texton_count(input logic [CFG_W-1:0] setting);
      drain_block();
      csr_write_enable <= 1'b1;
      csr_write_data   <= setting;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      texton_count_setting = setting;
   endtask

   // ------------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------------

   // Fill every codebook word before any pixel reads one. Texton 0 is all
   // ones and texton 1 all zeros for the extreme patches; the rest is random.
   task automatic test_codebook_load();
      int unsigned word;
      req_quiet = 1'b0;
      rsp_quiet = 1'b0;
      for (int t = 0; t < NUM_TEXTONS; t++) begin
         // Run the second half back to back
         if (t == NUM_TEXTONS / 2) req_quiet = 1'b1;
         for (int e = 0; e < PATCH_LEN; e++) begin
            word = (t == 0) ? 16'hFFFF : (t == 1) ? 16'h0000 : $urandom_range(0, 65535);
            send_load(t, e, word);
         end
      end
      // Writes past the patch end and kind 3 must leave the codebook alone
      for (int e = PATCH_LEN; e < 32; e++)
         send_load($urandom_range(0, 31), e, $urandom_range(0, 65535));
      send_request(random_item(KIND_UNUSED));
   endtask

   task automatic test_extreme_patches();
      req_quiet = 1'b0;
      rsp_quiet = 1'b0;
      // Zero patch hits the all-zero texton at distance zero
      send_flat_patch(8'd0);
      // A count of zero acts as one: only the all-ones texton is searched,
      // which gives the largest possible distance
      write_texton_count(6'd0);
      send_flat_patch(8'd0);
      send_readout();
      // All bits set acts as the full codebook
      write_texton_count(6'd63);
      send_flat_patch(8'd255);
      send_readout();
      write_texton_count(TEXTON_COUNT_RESET);
   endtask

   // Make texton 2 a copy of texton 1 so the zero patch ties; the lower
   // index must win. Then give texton 2 random content again.
   task automatic test_tie_break();
      req_quiet = 1'b1;
      rsp_quiet = 1'b0;
      for (int e = 0; e < PATCH_LEN; e++) send_load(2, e, 0);
      send_flat_patch(8'd0);
      for (int e = 0; e < PATCH_LEN; e++) send_load(2, e, $urandom_range(0, 65535));
   endtask

   // A readout in the middle of a patch must not disturb the running sums
   task automatic test_readout_mid_patch();
      req_quiet = 1'b0;
      rsp_quiet = 1'b1;
      repeat (12) send_pixel(grey_near(5, patch_position));
      send_readout();
      repeat (PATCH_LEN - 12) send_pixel(grey_near(5, patch_position));
      send_readout();
   endtask

   // Phases of random traffic, each under its own texton count. Most of it
   // is whole patches near a texton in use; the rest is scattered patches,
   // readouts, codebook rewrites and items the block drops.
   task automatic test_random_traffic();
      int unsigned start_items;
      int unsigned start_patches;
      int unsigned phase;
      int unsigned pick;
      logic [CFG_W-1:0] setting;
      start_items   = useful_items;
      start_patches = patches_classified;
      phase = 0;
      while (useful_items - start_items < RANDOM_ITEMS ||
             patches_classified - start_patches < RANDOM_PATCHES) begin
         case (phase)
            0:       setting = 6'd63;
            1:       setting = 6'd1;
            2:       setting = 6'd32;
            3:       setting = 6'd0;
            4:       setting = 6'd33;
            5:       setting = 6'd2;
            default: setting = CFG_W'($urandom_range(1, NUM_TEXTONS));
         endcase
         write_texton_count(setting);
         repeat (10) begin
            req_quiet = ($urandom_range(0, 3) == 0);
            rsp_quiet = ($urandom_range(0, 3) == 0);
            pick = $urandom_range(0, 19);
            if (pick < 12)
               send_patch($urandom_range(0, textons_searched() - 1), 1'b0);
            else if (pick < 14)
               send_patch(0, 1'b1);
            else if (pick < 16)
               send_readout();
            else if (pick < 19)
               repeat ($urandom_range(1, 5))
                  send_load($urandom_range(0, 31), $urandom_range(0, PATCH_LEN - 1),
                            $urandom_range(0, 65535));
            else
               send_noise();
         end
         phase++;
      end
   endtask

   // ------------------------------------------------------------------------
   // Sequence
   // ------------------------------------------------------------------------
   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      test_codebook_load();
      test_extreme_patches();
      test_tie_break();
      test_readout_mid_patch();
      test_random_traffic();
      drain_block();
      if (mismatch_count == 0 && reports_due.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

   // Hard stop well past the slowest correct run
   initial begin
      #RUN_LIMIT;
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule
